### src/ptp_pkg.sv
package ptp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int DIV_STAGES = NUM_W;
  localparam int LATENCY    = 4 + DIV_STAGES;

  typedef enum logic [2:0] {
    MODE_IDENTITY   = 3'd0,
    MODE_TRANSLATE  = 3'd1,
    MODE_SCALE      = 3'd2,
    MODE_SWAP       = 3'd3,
    MODE_AFFINE     = 3'd4,
    MODE_PROJECTIVE = 3'd5,
    MODE_DEGENERATE = 3'd6
  } mode_t;

  localparam logic [2:0] CFG_MODE        = 3'd0;
  localparam logic [2:0] CFG_SCALE_PAIR  = 3'd1;
  localparam logic [2:0] CFG_SHEAR_PAIR  = 3'd2;
  localparam logic [2:0] CFG_OFFSET_PAIR = 3'd3;
  localparam logic [2:0] CFG_PERSP_PAIR  = 3'd4;
  localparam logic [2:0] CFG_PERSP_CONST = 3'd5;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic               in_last;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               out_last;
  } result_t;

  // Side information that rides along the divider.
  typedef struct packed {
    logic               last;
    logic               proj;
    logic               neg_x;
    logic               neg_y;
    logic signed [31:0] byp_x;
    logic signed [31:0] byp_y;
  } side_t;

  typedef struct packed {
    logic [31:0]      rem;
    logic [NUM_W-1:0] num;
  } div_lane_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // One restoring division step: brings in the next numerator bit and
  // shifts the quotient bit into the bottom of the numerator word.
  function automatic div_lane_t div_step(input div_lane_t a, input logic [31:0] d);
    div_lane_t   r;
    logic [32:0] t;
    logic        q;
    t = {a.rem, a.num[NUM_W-1]};
    q = (t >= {1'b0, d});
    if (q) r.rem = 32'(t - {1'b0, d});
    else r.rem = t[31:0];
    r.num = {a.num[NUM_W-2:0], q};
    return r;
  endfunction

endpackage

### src/ptp_div.sv
module ptp_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [ptp_pkg::NUM_W-1:0] in_num_x,
  input  logic [ptp_pkg::NUM_W-1:0] in_num_y,
  input  logic [31:0]             in_den,
  input  ptp_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [ptp_pkg::NUM_W-1:0] out_q_x,
  output logic [ptp_pkg::NUM_W-1:0] out_q_y,
  output ptp_pkg::side_t          out_side
);

  logic                valid [ptp_pkg::DIV_STAGES];
  ptp_pkg::div_lane_t  lane_x [ptp_pkg::DIV_STAGES];
  ptp_pkg::div_lane_t  lane_y [ptp_pkg::DIV_STAGES];
  logic [31:0]         den [ptp_pkg::DIV_STAGES];
  ptp_pkg::side_t      side [ptp_pkg::DIV_STAGES];

  ptp_pkg::div_lane_t  first_x;
  ptp_pkg::div_lane_t  first_y;

  assign first_x = '{rem: 32'd0, num: in_num_x};
  assign first_y = '{rem: 32'd0, num: in_num_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ptp_pkg::DIV_STAGES; k++) valid[k] <= 1'b0;
    end else begin
      valid[0] <= in_valid;
      for (int k = 1; k < ptp_pkg::DIV_STAGES; k++) valid[k] <= valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    lane_x[0] <= ptp_pkg::div_step(first_x, in_den);
    lane_y[0] <= ptp_pkg::div_step(first_y, in_den);
    den[0]    <= in_den;
    side[0]   <= in_side;
    for (int k = 1; k < ptp_pkg::DIV_STAGES; k++) begin
      lane_x[k] <= ptp_pkg::div_step(lane_x[k-1], den[k-1]);
      lane_y[k] <= ptp_pkg::div_step(lane_y[k-1], den[k-1]);
      den[k]    <= den[k-1];
      side[k]   <= side[k-1];
    end
  end

  assign out_valid = valid[ptp_pkg::DIV_STAGES-1];
  assign out_q_x   = lane_x[ptp_pkg::DIV_STAGES-1].num;
  assign out_q_y   = lane_y[ptp_pkg::DIV_STAGES-1].num;
  assign out_side  = side[ptp_pkg::DIV_STAGES-1];

endmodule

### src/point_transform_2d_projective_top.sv
// Path from an accepted start to done: stages 1 to 3, the divider, then the final stage.
// Throughput: one point per cycle; busy never rises, as every stage advances each cycle.
// The depth is set by the restoring divider, one quotient bit per stage.
// Synchronous reset empties the pipeline and loads the identity matrix registers.
// The receiver cannot stall: each result is shown for one cycle with done high.
module point_transform_2d_projective_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  ptp_pkg::point_t  point,
  output logic             done,
  output ptp_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [63:0]      cfg_data
);

  logic [2:0]  mode;
  logic [63:0] scale_pair;
  logic [63:0] shear_pair;
  logic [63:0] offset_pair;
  logic [63:0] persp_pair;
  logic [31:0] persp_const;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 3'd0;
      scale_pair  <= 64'h0001_0000_0001_0000;
      shear_pair  <= 64'd0;
      offset_pair <= 64'd0;
      persp_pair  <= 64'd0;
      persp_const <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptp_pkg::CFG_MODE:        mode        <= cfg_data[2:0];
        ptp_pkg::CFG_SCALE_PAIR:  scale_pair  <= cfg_data;
        ptp_pkg::CFG_SHEAR_PAIR:  shear_pair  <= cfg_data;
        ptp_pkg::CFG_OFFSET_PAIR: offset_pair <= cfg_data;
        ptp_pkg::CFG_PERSP_PAIR:  persp_pair  <= cfg_data;
        ptp_pkg::CFG_PERSP_CONST: persp_const <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] a00, a11, a10, a01, a20, a21, a02, a12, a22;
  assign a00 = scale_pair[63:32];
  assign a11 = scale_pair[31:0];
  assign a10 = shear_pair[63:32];
  assign a01 = shear_pair[31:0];
  assign a20 = offset_pair[63:32];
  assign a21 = offset_pair[31:0];
  assign a02 = persp_pair[63:32];
  assign a12 = persp_pair[31:0];
  assign a22 = persp_const;

  // Stage 1: the six products, floored by an arithmetic shift.
  logic               s1_valid;
  logic signed [31:0] s1_x, s1_y;
  logic               s1_last;
  logic signed [63:0] p00, p10, p01, p11, p02, p12;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_x    <= point.in_x;
    s1_y    <= point.in_y;
    s1_last <= point.in_last;
    p00 <= (64'(point.in_x) * 64'(a00)) >>> ptp_pkg::FRAC_BITS;
    p10 <= (64'(point.in_y) * 64'(a10)) >>> ptp_pkg::FRAC_BITS;
    p01 <= (64'(point.in_x) * 64'(a01)) >>> ptp_pkg::FRAC_BITS;
    p11 <= (64'(point.in_y) * 64'(a11)) >>> ptp_pkg::FRAC_BITS;
    p02 <= (64'(point.in_x) * 64'(a02)) >>> ptp_pkg::FRAC_BITS;
    p12 <= (64'(point.in_y) * 64'(a12)) >>> ptp_pkg::FRAC_BITS;
  end

  // Stage 2: mode selection, sums and saturation.
  logic signed [63:0] sum_x, sum_y, sum_w;
  logic               sel_proj;

  always_comb begin
    sum_x    = 64'sd0;
    sum_y    = 64'sd0;
    sel_proj = 1'b0;
    sum_w    = p02 + p12 + 64'(a22);
    case (mode) inside
      ptp_pkg::MODE_IDENTITY: begin
        sum_x = 64'(s1_x);
        sum_y = 64'(s1_y);
      end
      ptp_pkg::MODE_TRANSLATE: begin
        sum_x = 64'(s1_x) + 64'(a20);
        sum_y = 64'(s1_y) + 64'(a21);
      end
      ptp_pkg::MODE_SCALE: begin
        sum_x = p00 + 64'(a20);
        sum_y = p11 + 64'(a21);
      end
      ptp_pkg::MODE_SWAP: begin
        sum_x = p10 + 64'(a20);
        sum_y = p01 + 64'(a21);
      end
      ptp_pkg::MODE_AFFINE, ptp_pkg::MODE_PROJECTIVE: begin
        sum_x    = p00 + p10 + 64'(a20);
        sum_y    = p01 + p11 + 64'(a21);
        sel_proj = (mode == ptp_pkg::MODE_PROJECTIVE);
      end
      default: ;
    endcase
  end

  logic               s2_valid;
  logic signed [31:0] s2_nx, s2_ny, s2_w;
  logic               s2_proj, s2_last;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_nx   <= ptp_pkg::sat32(sum_x);
    s2_ny   <= ptp_pkg::sat32(sum_y);
    // A w below one LSB in magnitude is taken as one LSB.
    s2_w    <= (ptp_pkg::sat32(sum_w) == 32'sd0) ? 32'sd1 : ptp_pkg::sat32(sum_w);
    s2_proj <= sel_proj;
    s2_last <= s1_last;
  end

  // Stage 3: magnitudes and signs for the divider.
  logic                      s3_valid;
  logic [ptp_pkg::NUM_W-1:0] s3_num_x, s3_num_y;
  logic [31:0]               s3_den;
  ptp_pkg::side_t            s3_side;
  logic [31:0]               mag_x, mag_y;

  assign mag_x = s2_nx[31] ? 32'(-s2_nx) : 32'(s2_nx);
  assign mag_y = s2_ny[31] ? 32'(-s2_ny) : 32'(s2_ny);

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_num_x      <= {mag_x, {ptp_pkg::FRAC_BITS{1'b0}}};
    s3_num_y      <= {mag_y, {ptp_pkg::FRAC_BITS{1'b0}}};
    s3_den        <= s2_w[31] ? 32'(-s2_w) : 32'(s2_w);
    s3_side.last  <= s2_last;
    s3_side.proj  <= s2_proj;
    s3_side.neg_x <= s2_nx[31] ^ s2_w[31];
    s3_side.neg_y <= s2_ny[31] ^ s2_w[31];
    s3_side.byp_x <= s2_nx;
    s3_side.byp_y <= s2_ny;
  end

  logic                      dv_valid;
  logic [ptp_pkg::NUM_W-1:0] dv_q_x, dv_q_y;
  ptp_pkg::side_t            dv_side;

  ptp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_num_x  (s3_num_x),
    .in_num_y  (s3_num_y),
    .in_den    (s3_den),
    .in_side   (s3_side),
    .out_valid (dv_valid),
    .out_q_x   (dv_q_x),
    .out_q_y   (dv_q_y),
    .out_side  (dv_side)
  );

  // Final stage: sign restore and saturation of the quotients, or the stage 2 values outside projective mode.
  function automatic logic signed [31:0] fix_q(input logic [ptp_pkg::NUM_W-1:0] q,
                                               input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      if (q > ptp_pkg::NUM_W'(32'h7fffffff)) r = 32'sh7fffffff;
      else r = q[31:0];
    end else begin
      if (q > ptp_pkg::NUM_W'(33'h80000000)) r = 32'sh80000000;
      else r = 32'(-q[31:0]);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv_valid;
  end

  always_ff @(posedge clk) begin
    result.out_last <= dv_side.last;
    result.out_x    <= dv_side.proj ? fix_q(dv_q_x, dv_side.neg_x) : dv_side.byp_x;
    result.out_y    <= dv_side.proj ? fix_q(dv_q_y, dv_side.neg_y) : dv_side.byp_y;
  end

  // A result only ever follows an accepted beat by the full pipeline depth.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ptp_pkg::LATENCY))
    else $error("result without a matching accepted beat");

  a_done_after_reset: assert property (@(posedge clk)
    done |-> !$past(rst))
    else $error("result straight after reset");

endmodule
